// ===== rtl/core/caldate_pkg.sv =====
// caldate_pkg: shared types, constants and date helper functions for the calendar date counter
package caldate_pkg;

  localparam int MONTH_W = 4;
  localparam int DAY_W   = 5;
  localparam int YEAR_W  = 14;

  typedef logic [MONTH_W-1:0] month_t;
  typedef logic [DAY_W-1:0]   day_t;
  typedef logic [YEAR_W-1:0]  year_t;

  typedef enum logic [1:0] {
    ACT_SET  = 2'd0,
    ACT_NEXT = 2'd1,
    ACT_CMP  = 2'd2
  } action_t;

  typedef enum logic [1:0] {
    ORD_EQUAL   = 2'd0,
    ORD_EARLIER = 2'd1,
    ORD_LATER   = 2'd2
  } order_t;

  localparam month_t MONTH_FIRST  = 4'd1;
  localparam month_t MONTH_LAST   = 4'd12;
  localparam day_t   DAY_FIRST    = 5'd1;
  localparam day_t   DAY_LAST     = 5'd31;
  localparam year_t  YEAR_DEFAULT = 14'd1900;
  localparam year_t  YEAR_MIN     = 14'd1000;
  localparam year_t  YEAR_MAX     = 14'd9999;

  // y is a multiple of 25 iff y * inv(25) mod 2^14 <= floor((2^14 - 1) / 25)
  localparam year_t  INV25        = 14'd7209;
  localparam year_t  DIV25_LIMIT  = 14'd655;

  // leap: divisible by 400, or by 4 and not by 100 (400 = 16 * 25, 100 = 4 * 25)
  function automatic logic is_leap(input year_t y);
    year_t prod;
    logic  by25;
    // only the product mod 2^14 is needed
    prod = y * INV25;
    by25 = (prod <= DIV25_LIMIT);
    return ((y[3:0] == 4'd0) && by25) || ((y[1:0] == 2'd0) && !by25);
  endfunction

  // month length; a month outside 1..12 counts as 31 days
  function automatic day_t days_in(input month_t m, input logic leap);
    day_t len;
    case (m)
      4'd2:                      len = leap ? 5'd29 : 5'd28;
      4'd4, 4'd6, 4'd9, 4'd11:   len = 5'd30;
      default:                   len = 5'd31;
    endcase
    return len;
  endfunction

endpackage

// ===== rtl/core/calendar_date_counter.sv =====
// calendar_date_counter: gregorian date register with set, advance and compare requests
//
//   channel | dir | handshake         | payload
//   --------+-----+-------------------+--------------------------------------------------
//   in_     | in  | in_tvalid/tready  | tuser action, tdata month, day, year
//   out_    | out | out_tvalid/tready | tdata month, day, year, ok flags, order
//
// one request per cycle sustained while the output is not stalled; each result passes
// through the input register, then the date update and result register.
// rst_n (synchronous, active low) loads 1 jan 1900 and empties both stages.
// a stalled output holds its result; the input stage accepts while empty, or while the
// output register is free or being drained in the same cycle.
module calendar_date_counter (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [23:0] in_tdata,   // month[3:0], day[8:4], year[22:9], zero[23]
  input  logic [1:0]  in_tuser,   // action[1:0]
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [31:0] out_tdata   // month[3:0], day[8:4], year[22:9], month_ok[23],
                                  // day_ok[24], year_ok[25], order[27:26], zero[31:28]
);
  import caldate_pkg::*;

  // input stage
  logic       s1_valid_r;
  logic [1:0] s1_action_r;
  month_t     s1_month_r;
  day_t       s1_day_r;
  year_t      s1_year_r;

  // stored date
  month_t     cur_month_r, cur_month_nxt;
  day_t       cur_day_r,   cur_day_nxt;
  year_t      cur_year_r,  cur_year_nxt;

  // result register
  logic       out_valid_r;
  month_t     out_month_r;
  day_t       out_day_r;
  year_t      out_year_r;
  logic       out_mok_r, out_mok_nxt;
  logic       out_dok_r, out_dok_nxt;
  logic       out_yok_r, out_yok_nxt;
  logic [1:0] out_order_r, out_order_nxt;

  logic       s1_adv;
  logic       in_acc;

  logic       set_mok, set_yok, set_dok;
  month_t     set_month;
  year_t      set_year;
  day_t       set_dim;
  day_t       cur_dim;

  assign s1_adv    = s1_valid_r && (!out_valid_r || out_tready);
  assign in_tready = !s1_valid_r || s1_adv;
  assign in_acc    = in_tvalid && in_tready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (in_tready) begin
      s1_valid_r <= in_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc) begin
      s1_action_r <= in_tuser;
      s1_month_r  <= in_tdata[3:0];
      s1_day_r    <= in_tdata[8:4];
      s1_year_r   <= in_tdata[22:9];
    end
  end

  // set path: month, then year, then day against the new month and year
  always_comb begin
    set_mok   = (s1_month_r >= MONTH_FIRST) && (s1_month_r <= MONTH_LAST);
    set_month = set_mok ? s1_month_r : MONTH_FIRST;
    set_yok   = (s1_year_r >= YEAR_MIN) && (s1_year_r <= YEAR_MAX);
    set_year  = set_yok ? s1_year_r : YEAR_DEFAULT;
    // default year 1900 is not a leap year
    set_dim   = days_in(set_month, set_yok && is_leap(s1_year_r));
    set_dok   = (s1_day_r >= DAY_FIRST) && (s1_day_r <= set_dim);
    cur_dim   = days_in(cur_month_r, is_leap(cur_year_r));
  end

  always_comb begin
    cur_month_nxt = cur_month_r;
    cur_day_nxt   = cur_day_r;
    cur_year_nxt  = cur_year_r;
    out_mok_nxt   = 1'b1;
    out_dok_nxt   = 1'b1;
    out_yok_nxt   = 1'b1;
    out_order_nxt = ORD_EQUAL;
    case (s1_action_r)
      ACT_SET: begin
        cur_month_nxt = set_month;
        cur_year_nxt  = set_year;
        cur_day_nxt   = set_dok ? s1_day_r : DAY_FIRST;
        out_mok_nxt   = set_mok;
        out_dok_nxt   = set_dok;
        out_yok_nxt   = set_yok;
      end
      ACT_NEXT: begin
        if ((cur_month_r == MONTH_LAST) && (cur_day_r == DAY_LAST)) begin
          cur_month_nxt = MONTH_FIRST;
          cur_day_nxt   = DAY_FIRST;
          cur_year_nxt  = cur_year_r + 14'd1;  // wraps at 2^14
        end else if (cur_day_r >= cur_dim) begin
          cur_month_nxt = (cur_month_r >= MONTH_LAST) ? MONTH_FIRST : cur_month_r + 4'd1;
          cur_day_nxt   = DAY_FIRST;
        end else begin
          cur_day_nxt   = cur_day_r + 5'd1;
        end
      end
      ACT_CMP: begin
        if (cur_year_r != s1_year_r) begin
          out_order_nxt = (cur_year_r < s1_year_r) ? ORD_EARLIER : ORD_LATER;
        end else if (cur_month_r != s1_month_r) begin
          out_order_nxt = (cur_month_r < s1_month_r) ? ORD_EARLIER : ORD_LATER;
        end else if (cur_day_r != s1_day_r) begin
          out_order_nxt = (cur_day_r < s1_day_r) ? ORD_EARLIER : ORD_LATER;
        end else begin
          out_order_nxt = ORD_EQUAL;
        end
      end
      default: begin
        // unused action: date and flags stay at their defaults
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cur_month_r <= MONTH_FIRST;
      cur_day_r   <= DAY_FIRST;
      cur_year_r  <= YEAR_DEFAULT;
    end else if (s1_adv) begin
      cur_month_r <= cur_month_nxt;
      cur_day_r   <= cur_day_nxt;
      cur_year_r  <= cur_year_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (!out_valid_r || out_tready) begin
      out_valid_r <= s1_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_adv) begin
      out_month_r <= cur_month_nxt;
      out_day_r   <= cur_day_nxt;
      out_year_r  <= cur_year_nxt;
      out_mok_r   <= out_mok_nxt;
      out_dok_r   <= out_dok_nxt;
      out_yok_r   <= out_yok_nxt;
      out_order_r <= out_order_nxt;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {4'd0, out_order_r, out_yok_r, out_dok_r, out_mok_r,
                       out_year_r, out_day_r, out_month_r};

  // stored date is always a real calendar date
  a_cur_month_range: assert property (@(posedge clk) disable iff (!rst_n)
    (cur_month_r >= MONTH_FIRST) && (cur_month_r <= MONTH_LAST))
    else $error("stored month out of range");

  a_cur_day_range: assert property (@(posedge clk) disable iff (!rst_n)
    (cur_day_r >= DAY_FIRST) && (cur_day_r <= days_in(cur_month_r, is_leap(cur_year_r))))
    else $error("stored day does not fit its month");

  // date only moves when a request leaves the input stage
  a_state_hold: assert property (@(posedge clk) disable iff (!rst_n)
    !s1_adv |=> ($stable(cur_month_r) && $stable(cur_day_r) && $stable(cur_year_r)))
    else $error("stored date changed without a request");

  // a presented result carries a valid month
  a_out_month: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> ((out_month_r >= MONTH_FIRST) && (out_month_r <= MONTH_LAST)))
    else $error("result month out of range");

endmodule

// ===== tb/calendar_date_checker.sv =====
// calendar_date_checker: tracks requests and results of the date counter and scores each result
`timescale 1ns / 100ps

module calendar_date_checker (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  input  logic        in_tready,
  input  logic [23:0] in_tdata,   // month[3:0], day[8:4], year[22:9], zero[23]
  input  logic [1:0]  in_tuser,   // action[1:0]
  input  logic        out_tvalid,
  input  logic        out_tready,
  input  logic [31:0] out_tdata,  // month[3:0], day[8:4], year[22:9], month_ok[23],
                                  // day_ok[24], year_ok[25], order[27:26], zero[31:28]
  output int          fail_count,
  output int          pending
);
  import caldate_pkg::*;

  typedef struct packed {
    logic [3:0] zero;
    order_t     order;
    logic       year_ok;
    logic       day_ok;
    logic       month_ok;
    year_t      year;
    day_t       day;
    month_t     month;
  } date_result_t;

  month_t       cal_month;
  day_t         cal_day;
  year_t        cal_year;
  date_result_t expected_dates[$];
  int           results_seen;

  function automatic logic leap_year(input year_t y);
    return (y % 400 == 0) || ((y % 4 == 0) && (y % 100 != 0));
  endfunction

  function automatic day_t month_length(input month_t m, input year_t y);
    case (m)
      4'd2:                    return leap_year(y) ? 5'd29 : 5'd28;
      4'd4, 4'd6, 4'd9, 4'd11: return 5'd30;
      default:                 return 5'd31;
    endcase
  endfunction

  // updates the tracked date for one request and returns the result it should produce
  function automatic date_result_t apply_request(input logic [1:0] act, input month_t m,
                                                 input day_t d, input year_t y);
    date_result_t res;
    res = '0;
    res.month_ok = 1'b1;
    res.day_ok   = 1'b1;
    res.year_ok  = 1'b1;
    res.order    = ORD_EQUAL;
    case (act)
      ACT_SET: begin
        if (m >= MONTH_FIRST && m <= MONTH_LAST) begin
          cal_month = m;
        end else begin
          cal_month    = MONTH_FIRST;
          res.month_ok = 1'b0;
        end
        if (y >= YEAR_MIN && y <= YEAR_MAX) begin
          cal_year = y;
        end else begin
          cal_year    = YEAR_DEFAULT;
          res.year_ok = 1'b0;
        end
        // day is checked against the month and year just loaded
        if (d >= DAY_FIRST && d <= month_length(cal_month, cal_year)) begin
          cal_day = d;
        end else begin
          cal_day    = DAY_FIRST;
          res.day_ok = 1'b0;
        end
      end
      ACT_NEXT: begin
        if (cal_month == MONTH_LAST && cal_day == DAY_LAST) begin
          cal_month = MONTH_FIRST;
          cal_day   = DAY_FIRST;
          cal_year  = cal_year + 14'd1;
        end else if (cal_day >= month_length(cal_month, cal_year)) begin
          cal_month = (cal_month >= MONTH_LAST) ? MONTH_FIRST : cal_month + 4'd1;
          cal_day   = DAY_FIRST;
        end else begin
          cal_day = cal_day + 5'd1;
        end
      end
      ACT_CMP: begin
        if (cal_year != y)
          res.order = (cal_year < y) ? ORD_EARLIER : ORD_LATER;
        else if (cal_month != m)
          res.order = (cal_month < m) ? ORD_EARLIER : ORD_LATER;
        else if (cal_day != d)
          res.order = (cal_day < d) ? ORD_EARLIER : ORD_LATER;
      end
      default: ;
    endcase
    res.month = cal_month;
    res.day   = cal_day;
    res.year  = cal_year;
    return res;
  endfunction

  task automatic flag_error(input string msg);
    $display("[%0t] error: %s", $realtime, msg);
    fail_count++;
  endtask

  task automatic check_field(input string name, input logic [13:0] got_v,
                             input logic [13:0] want_v);
    if (got_v !== want_v)
      flag_error($sformatf("result %0d %s: got %0d expected %0d", results_seen, name,
                           got_v, want_v));
  endtask

  always @(posedge clk) begin : track
    date_result_t got_res;
    date_result_t want_res;
    if (!rst_n) begin
      cal_month  = MONTH_FIRST;
      cal_day    = DAY_FIRST;
      cal_year   = YEAR_DEFAULT;
      fail_count = 0;
      results_seen = 0;
      expected_dates.delete();
    end else begin
      // results leave only after their request has been registered, so score before queueing
      if (out_tvalid && out_tready) begin
        got_res = date_result_t'(out_tdata);
        if (expected_dates.size() == 0) begin
          flag_error($sformatf("result %0d arrived with no request pending", results_seen));
        end else begin
          want_res = expected_dates.pop_front();
          check_field("month", 14'(got_res.month), 14'(want_res.month));
          check_field("day", 14'(got_res.day), 14'(want_res.day));
          check_field("year", got_res.year, want_res.year);
          check_field("month_ok", 14'(got_res.month_ok), 14'(want_res.month_ok));
          check_field("day_ok", 14'(got_res.day_ok), 14'(want_res.day_ok));
          check_field("year_ok", 14'(got_res.year_ok), 14'(want_res.year_ok));
          check_field("order", 14'(got_res.order), 14'(want_res.order));
          check_field("zero", 14'(got_res.zero), 14'(want_res.zero));
        end
        results_seen++;
      end
      if (in_tvalid && in_tready)
        expected_dates.push_back(apply_request(in_tuser, in_tdata[3:0], in_tdata[8:4],
                                               in_tdata[22:9]));
    end
    pending <= expected_dates.size();
  end

endmodule

// ===== tb/testbench.sv =====
// testbench: drives directed and random date requests into the calendar date counter
`timescale 1ns / 100ps

module testbench;
  import caldate_pkg::*;

  localparam logic [1:0] ACT_UNUSED     = 2'd3;
  localparam int         RANDOM_PER_PHASE = 250;
  localparam int         WATCHDOG_LIMIT = 2000;
  localparam int         TAIL_CYCLES    = 8;

  logic        clk        = 1'b0;
  logic        rst_n      = 1'b0;
  logic        in_tvalid  = 1'b0;
  logic        in_tready;
  logic [23:0] in_tdata   = '0;  // month[3:0], day[8:4], year[22:9], zero[23]
  logic [1:0]  in_tuser   = '0;  // action[1:0]
  logic        out_tvalid;
  logic        out_tready = 1'b0;
  logic [31:0] out_tdata;        // month[3:0], day[8:4], year[22:9], month_ok[23],
                                 // day_ok[24], year_ok[25], order[27:26], zero[31:28]
  int          fail_count;
  int          pending;
  int          idle_pct   = 0;
  int          stall_pct  = 0;
  int          requests_sent = 0;
  int          quiet_cycles  = 0;

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  calendar_date_counter DUT (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata)
  );

  calendar_date_checker u_checker (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .fail_count (fail_count),
    .pending    (pending)
  );

  always @(posedge clk) begin
    out_tready <= ($urandom_range(99) >= stall_pct);
  end

  always @(posedge clk) begin
    if (!rst_n || (in_tvalid && in_tready) || (out_tvalid && out_tready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("calendar_date_counter verification failed");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  // valid stays high between back-to-back requests; it only drops for an idle gap
  task automatic send_request(input logic [1:0] act, input month_t m, input day_t d,
                              input year_t y);
    while ($urandom_range(99) < idle_pct) begin
      in_tvalid <= 1'b0;
      @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tuser  <= act;
    in_tdata  <= {1'b0, y, d, m};
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    requests_sent++;
  endtask

  task automatic wait_drain();
    in_tvalid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
  endtask

  function automatic year_t pick_year();
    case ($urandom_range(0, 5))
      0:       return $urandom_range(0, 1) ? YEAR_MIN : YEAR_MAX;
      1:       return year_t'($urandom_range(3, 24) * 400);
      2:       return year_t'($urandom_range(10, 99) * 100);
      3:       return year_t'($urandom_range(250, 2499) * 4);
      default: return year_t'($urandom_range(YEAR_MIN, YEAR_MAX));
    endcase
  endfunction

  // a set request with valid month and year, then a few advances, then a compare near the loaded date
  task automatic send_date_walk();
    month_t m;
    day_t   d;
    year_t  y;
    m = month_t'($urandom_range(MONTH_FIRST, MONTH_LAST));
    d = ($urandom_range(99) < 60) ? day_t'($urandom_range(27, 31))
                                  : day_t'($urandom_range(1, 31));
    y = pick_year();
    send_request(ACT_SET, m, d, y);
    repeat ($urandom_range(0, 4)) send_request(ACT_NEXT, m, d, y);
    case ($urandom_range(0, 9))
      4: y = y + 14'd1;
      5: y = y - 14'd1;
      6: m = m + 4'd1;
      7: m = m - 4'd1;
      8: d = d + 5'd1;
      9: d = d - 5'd1;
      default: ;
    endcase
    send_request(ACT_CMP, m, d, y);
  endtask

  task automatic run_random(input int count);
    int stop_at;
    int kind;
    stop_at = requests_sent + count;
    while (requests_sent < stop_at) begin
      kind = $urandom_range(99);
      if (kind < 75) begin
        send_date_walk();
      end else if (kind < 88) begin
        // longer runs of advances cross month and year boundaries
        repeat ($urandom_range(1, 40))
          send_request(ACT_NEXT, month_t'($urandom), day_t'($urandom), year_t'($urandom));
      end else begin
        send_request(2'($urandom_range(0, 3)), month_t'($urandom), day_t'($urandom),
                     year_t'($urandom));
      end
    end
  endtask

  initial begin
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;

    // directed requests, no idling
    send_request(ACT_CMP,  4'd1,  5'd1,  14'd1900);   // reset date equal
    send_request(ACT_SET,  4'd12, 5'd31, 14'd9999);
    send_request(ACT_NEXT, 4'd0,  5'd0,  14'd0);      // rolls into year 10000
    send_request(ACT_CMP,  4'd15, 5'd31, 14'd16383);  // unchecked compare, all ones
    send_request(ACT_CMP,  4'd0,  5'd0,  14'd0);      // unchecked compare, all zeros
    send_request(ACT_SET,  4'd2,  5'd29, 14'd2000);   // leap by 400
    send_request(ACT_NEXT, 4'd0,  5'd0,  14'd0);
    send_request(ACT_SET,  4'd2,  5'd29, 14'd1900);   // century, not leap
    send_request(ACT_SET,  4'd2,  5'd29, 14'd2004);
    send_request(ACT_NEXT, 4'd0,  5'd0,  14'd0);
    send_request(ACT_SET,  4'd2,  5'd28, 14'd2100);
    send_request(ACT_NEXT, 4'd0,  5'd0,  14'd0);
    send_request(ACT_SET,  4'd0,  5'd0,  14'd0);      // every part invalid
    send_request(ACT_SET,  4'd13, 5'd15, 14'd999);
    send_request(ACT_SET,  4'd15, 5'd31, 14'd16383);
    send_request(ACT_SET,  4'd4,  5'd31, 14'd1000);   // day past a 30-day month
    send_request(ACT_SET,  4'd4,  5'd30, 14'd10000);
    send_request(ACT_NEXT, 4'd0,  5'd0,  14'd0);
    send_request(ACT_SET,  4'd6,  5'd15, 14'd2024);
    send_request(ACT_CMP,  4'd6,  5'd15, 14'd2024);
    send_request(ACT_CMP,  4'd6,  5'd16, 14'd2024);
    send_request(ACT_CMP,  4'd5,  5'd15, 14'd2024);
    send_request(ACT_CMP,  4'd6,  5'd15, 14'd2025);
    send_request(ACT_CMP,  4'd6,  5'd14, 14'd2023);
    send_request(ACT_UNUSED, 4'd3, 5'd3, 14'd3);

    run_random(RANDOM_PER_PHASE);
    wait_drain();

    idle_pct = 63;
    run_random(RANDOM_PER_PHASE);
    wait_drain();

    idle_pct = 0;
    stall_pct <= 63;
    run_random(RANDOM_PER_PHASE);
    wait_drain();

    idle_pct = 22;
    stall_pct <= 22;
    run_random(RANDOM_PER_PHASE);
    wait_drain();

    repeat (TAIL_CYCLES) @(posedge clk);
    if (fail_count == 0 && pending == 0) begin
      $display("calendar_date_counter verification clean");
    end else begin
      $display("calendar_date_counter verification failed");
    end
    $finish;
  end

endmodule
